// ----- hw/rtl/fpc_pkg.sv -----
package fpc_pkg;

  localparam int HISTORY_DEPTH_DEF = 300;

  localparam logic [9:0]  TARGET_FPS_RST   = 10'd60;
  localparam logic [29:0] FRAME_PERIOD_RST = 30'd16666666;
  localparam logic        FREE_RUN_RST     = 1'b0;
  localparam logic [63:0] ONE_SECOND_NS    = 64'd1000000000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TARGET_FPS   = 2'd0;
  localparam logic [1:0] CFG_FRAME_PERIOD = 2'd1;
  localparam logic [1:0] CFG_FREE_RUN     = 2'd2;

  // Input function codes.
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic        sub;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        lt;
  } alu_rsp_t;

endpackage

// ----- hw/rtl/fpc_ram.sv -----
module fpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 300,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/fpc_alu.sv -----
module fpc_alu (
  input  fpc_pkg::alu_req_t req,
  output fpc_pkg::alu_rsp_t rsp
);
  import fpc_pkg::*;

  logic [63:0] b_op;

  // One 64-bit adder/subtractor and one signed compare, shared by the arithmetic steps.
  always_comb begin
    b_op    = req.sub ? ~req.b : req.b;
    rsp.sum = req.a + b_op + {63'd0, req.sub};
    rsp.lt  = $signed(req.a) < $signed(req.b);
  end

endmodule

// ----- hw/rtl/frame_pacer_with_rate_counter.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_stall    func, now_ns
// out       out_valid / out_stall  frames_in_last_second, frame_delta_ns,
//                                  next_deadline_ns, lag_detected
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A start event gives no result and leaves in_stall low.
// A frame event holds in_stall high through S_DELTA, then S_CMP, S_DL, S_MK
// (paced) or S_FREE (free-run), then S_WR, S_RD, one S_ACC/S_CHK pair per
// history entry read (at most target_fps) and S_OUT, S_RD being skipped when
// target_fps is zero. Per entry, the shared ALU sums, then compares with one second.
// Reset clears pacing state and config to defaults; unwritten history
// entries read as zero through a fill flag, so no clearing pass is needed.
// A finished result waits in the output register while out_stall is high;
// in_stall is high from a frame transfer until its result is loaded.
module frame_pacer_with_rate_counter #(
  parameter int HISTORY_DEPTH = fpc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [62:0] now_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  frames_in_last_second,
  output logic [63:0] frame_delta_ns,
  output logic [62:0] next_deadline_ns,
  output logic        lag_detected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data
);
  import fpc_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DL    = 4'd3;
  localparam logic [3:0] S_MK    = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]       state;
  logic [9:0]       target_fps;
  logic [29:0]      frame_period_ns;
  logic             free_run;
  logic [PTR_W-1:0] ptr;
  logic             full;

  logic [62:0]      now_q;
  logic [63:0]      mark;
  logic [63:0]      deadline;
  logic [63:0]      delta;
  logic             lag;
  logic [63:0]      sum;
  logic [9:0]       tally;
  logic [PTR_W-1:0] idx;
  logic             rd_valid;

  logic [63:0]      now_ext;
  logic [63:0]      period_ext;
  logic [63:0]      period_x2;
  logic [9:0]       tally_inc;
  logic [PTR_W-1:0] idx_dec;
  logic             in_xfer;
  logic             out_load;
  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [63:0]      ram_rdata;
  logic [63:0]      rd_val;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_load   = (state == S_OUT) && (!out_valid || !out_stall);
  assign now_ext    = {1'b0, now_q};
  assign period_ext = {34'd0, frame_period_ns};
  assign period_x2  = {33'd0, frame_period_ns, 1'b0};
  assign tally_inc  = tally + 10'd1;
  assign idx_dec    = (idx == '0) ? PTR_LAST : idx - PTR_W'(1);
  assign rd_val     = rd_valid ? ram_rdata : 64'd0;
  assign ram_we     = (state == S_WR);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx;
    if (state == S_RD) begin
      ram_re = 1'b1;
    end else if (state == S_CHK) begin
      // Fetch the next older entry early; it is dropped if the walk ends.
      ram_re    = 1'b1;
      ram_raddr = idx_dec;
    end
  end

  always_comb begin
    alu_req = '0;
    case (state)
      S_DELTA: begin
        alu_req.sub = 1'b1;
        alu_req.a   = now_ext;
        alu_req.b   = mark;
      end
      S_CMP: begin
        alu_req.a = delta;
        alu_req.b = period_x2;
      end
      S_DL: begin
        alu_req.a = lag ? now_ext : mark;
        alu_req.b = lag ? period_ext : period_x2;
      end
      S_MK: begin
        alu_req.a = mark;
        alu_req.b = period_ext;
      end
      S_ACC: begin
        alu_req.a = sum;
        alu_req.b = rd_val;
      end
      S_CHK: begin
        alu_req.a = ONE_SECOND_NS;
        alu_req.b = sum;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  fpc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  fpc_ram #(
    .WIDTH (64),
    .DEPTH (HISTORY_DEPTH),
    .AW    (PTR_W)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (delta),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      target_fps      <= TARGET_FPS_RST;
      frame_period_ns <= FRAME_PERIOD_RST;
      free_run        <= FREE_RUN_RST;
      ptr             <= '0;
      full            <= 1'b0;
      out_valid       <= 1'b0;
      mark            <= 64'd0;
      deadline        <= 64'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_FPS:   target_fps      <= cfg_data[9:0];
          CFG_FRAME_PERIOD: frame_period_ns <= cfg_data;
          CFG_FREE_RUN:     free_run        <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (func == FUNC_START) begin
              mark     <= {1'b0, now_ns};
              deadline <= {1'b0, now_ns};
            end else begin
              state <= S_DELTA;
            end
          end
        end
        S_DELTA: state <= free_run ? S_FREE : S_CMP;
        S_CMP:   state <= S_DL;
        S_DL: begin
          deadline <= alu_rsp.sum;
          state    <= S_MK;
        end
        S_MK: begin
          mark  <= lag ? now_ext : alu_rsp.sum;
          state <= S_WR;
        end
        S_FREE: begin
          mark  <= now_ext;
          state <= S_WR;
        end
        S_WR:  state <= (target_fps == 10'd0) ? S_OUT : S_RD;
        S_RD:  state <= S_ACC;
        S_ACC: state <= S_CHK;
        S_CHK: begin
          if (alu_rsp.lt || (tally_inc == target_fps)) begin
            state <= S_OUT;
          end else begin
            state <= S_ACC;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
            if (ptr == PTR_LAST) begin
              ptr  <= '0;
              full <= 1'b1;
            end else begin
              ptr <= ptr + PTR_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_q <= now_ns;
    end
    if (ram_re) begin
      // Entries past the fill point were never written and read as zero.
      rd_valid <= full || (ram_raddr <= ptr);
    end
    case (state)
      S_DELTA: delta <= alu_rsp.sum;
      S_CMP:   lag   <= !alu_rsp.lt;
      S_FREE:  lag   <= 1'b0;
      S_WR: begin
        sum   <= 64'd0;
        tally <= 10'd0;
        idx   <= ptr;
      end
      S_ACC:   sum   <= alu_rsp.sum;
      S_CHK: begin
        if (!alu_rsp.lt) begin
          tally <= tally_inc;
          idx   <= idx_dec;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      frames_in_last_second <= tally;
      frame_delta_ns        <= delta;
      next_deadline_ns      <= deadline[62:0];
      lag_detected          <= lag;
    end
  end

endmodule

// ----- hw/rtl/fpc_checker.sv -----
module fpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] frame_delta_ns
);
  import fpc_pkg::*;

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_delta_ns))
    else $error("result dropped or changed while stalled");

  // A frame transfer sets in_stall and keeps the input side busy.
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_FRAME) |=> in_stall ##1 in_stall)
    else $error("frame event did not occupy the block");

  // A start event finishes at once and produces no result.
  a_start_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_START) |=> !in_stall && !$rose(out_valid))
    else $error("start event stalled the block or made a result");

  // A new result only appears after the block has been working on a frame.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a frame in progress");

  // Coming out of reset the block is empty and ready.
  a_reset_clean: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind frame_pacer_with_rate_counter fpc_checker u_fpc_checker (.*);
